>>> hw/rtl/smf_pkg.sv
package smf_pkg;

  // commands carried with each input item
  typedef enum logic [1:0] {
    CmdRxByte   = 2'd0,
    CmdTxHeader = 2'd1,
    CmdTxChar   = 2'd2,
    CmdTxEnd    = 2'd3
  } cmd_e;

  // kinds of result item
  typedef enum logic [1:0] {
    KindRxChar = 2'd0,
    KindRxEnd  = 2'd1,
    KindTxByte = 2'd2
  } kind_e;

  // one result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       status;
    logic       last;
  } res_t;

  // results produced by one input item, at most two
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } res_pair_t;

  localparam int unsigned RxLimitW   = 12;
  localparam int unsigned RxCntW     = 13;
  localparam logic [RxCntW-1:0] RxCntMax = '1;
  localparam logic [RxLimitW-1:0] RxLimitReset = 12'd256;

  localparam logic [6:0] SyncChar = 7'h10;
  localparam logic [6:0] NlChar   = 7'h0a;
  localparam logic [6:0] NulChar  = 7'h00;

endpackage

>>> hw/rtl/smf_core.sv
module smf_core import smf_pkg::*; #(
  parameter int unsigned MsgMax  = 256,
  parameter int unsigned TxCntW  = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RxLimitW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          data_i,
  output res_pair_t           res_o
);

  logic [RxLimitW-1:0] limit_q;
  logic                in_msg_q, in_msg_d;
  logic [RxCntW-1:0]   rx_cnt_q, rx_cnt_d, rx_inc;
  logic                seen_end_q, seen_end_d;
  logic [6:0]          end_char_q, end_char_d;
  logic [TxCntW-1:0]   tx_cnt_q, tx_cnt_d;
  logic                tx_stop_q, tx_stop_d;
  logic [6:0]          c;
  cmd_e                cmd;

  // receive limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= RxLimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign c      = data_i[6:0];
  assign cmd    = cmd_e'(cmd_i);
  assign rx_inc = (rx_cnt_q != RxCntMax) ? rx_cnt_q + RxCntW'(1) : rx_cnt_q;

  // next state and results for one item
  always_comb begin
    in_msg_d   = in_msg_q;
    rx_cnt_d   = rx_cnt_q;
    seen_end_d = seen_end_q;
    end_char_d = end_char_q;
    tx_cnt_d   = tx_cnt_q;
    tx_stop_d  = tx_stop_q;
    res_o.num  = 2'd0;
    res_o.res0 = '{kind: KindTxByte, data: 8'h00, status: 1'b0, last: 1'b1};
    res_o.res1 = '{kind: KindTxByte, data: 8'h00, status: 1'b0, last: 1'b1};
    unique case (cmd)
      CmdRxByte: begin
        if (c == SyncChar) begin
          in_msg_d = 1'b1;
        end else if (in_msg_q) begin
          if (c == NlChar || c == NulChar) begin
            if (!seen_end_q) begin
              seen_end_d = 1'b1;
              end_char_d = c;
            end
            in_msg_d   = 1'b0;
            rx_cnt_d   = '0;
            res_o.num  = 2'd1;
            res_o.res0 = '{kind: KindRxEnd, data: 8'h00,
                           status: (rx_cnt_q > {1'b0, limit_q}),
                           last: 1'b1};
          end else begin
            rx_cnt_d = rx_inc;
            if (rx_inc <= {1'b0, limit_q}) begin
              res_o.num  = 2'd1;
              res_o.res0 = '{kind: KindRxChar, data: {1'b0, c}, status: 1'b0,
                             last: 1'b1};
            end
          end
        end
      end
      CmdTxHeader: begin
        tx_cnt_d   = '0;
        tx_stop_d  = 1'b0;
        res_o.num  = 2'd2;
        res_o.res0 = '{kind: KindTxByte, data: {1'b0, SyncChar}, status: 1'b0,
                       last: 1'b0};
        res_o.res1 = '{kind: KindTxByte, data: data_i, status: 1'b0, last: 1'b1};
      end
      CmdTxChar: begin
        if (!tx_stop_q) begin
          if (data_i == 8'h00) begin
            tx_stop_d = 1'b1;
          end else if (tx_cnt_q < TxCntW'(MsgMax)) begin
            tx_cnt_d   = tx_cnt_q + TxCntW'(1);
            res_o.num  = 2'd1;
            res_o.res0 = '{kind: KindTxByte, data: data_i, status: 1'b0,
                           last: 1'b1};
          end
        end
      end
      CmdTxEnd: begin
        tx_cnt_d  = '0;
        tx_stop_d = 1'b0;
        if (seen_end_q) begin
          res_o.num  = 2'd1;
          res_o.res0 = '{kind: KindTxByte, data: {1'b0, end_char_q}, status: 1'b0,
                         last: 1'b1};
        end else begin
          res_o.num  = 2'd2;
          res_o.res0 = '{kind: KindTxByte, data: {1'b0, NulChar}, status: 1'b0,
                         last: 1'b0};
          res_o.res1 = '{kind: KindTxByte, data: {1'b0, NlChar}, status: 1'b0,
                         last: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // shared framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q   <= 1'b0;
      rx_cnt_q   <= '0;
      seen_end_q <= 1'b0;
      end_char_q <= '0;
      tx_cnt_q   <= '0;
      tx_stop_q  <= 1'b0;
    end else if (accept_i) begin
      in_msg_q   <= in_msg_d;
      rx_cnt_q   <= rx_cnt_d;
      seen_end_q <= seen_end_d;
      end_char_q <= end_char_d;
      tx_cnt_q   <= tx_cnt_d;
      tx_stop_q  <= tx_stop_d;
    end
  end

endmodule

>>> hw/rtl/smf_outq.sv
module smf_outq import smf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_pair_t pair_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      stall_i,
  output res_t      res_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  res_t              mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, wr_ptr1;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic [1:0]        n_push;
  logic              pop;

  assign n_push  = push_i ? pair_i.num : 2'd0;
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign res_o   = mem_q[rd_ptr_q];
  // room for two results must remain before an item is taken
  assign full_o  = (cnt_q > (PtrW + 1)'(Depth - 2));
  assign wr_ptr1 = wr_ptr_q + PtrW'(1);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PtrW + 1)'(n_push) - (PtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= pair_i.res0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr1] <= pair_i.res1;
    end
  end

endmodule

>>> hw/rtl/sync_message_framer_top.sv
// channel  | handshake               | payload
// input    | in_valid_i / in_stall_o | cmd_i, data_i
// output   | out_valid_o / out_stall_i | kind_o, byte_out_o, status_o, last_o
// config   | cfg_we_i                | cfg_data_i (rx_limit)
//
// when an item is taken, framing state updates at the accepting edge
// and its zero, one or two results enter a four-entry output queue
// the queue delivers one result per cycle while out_stall_i is low, so items with
// two results fill it faster than it drains; single-result items flow one per cycle
// in_stall_o is high while the queue holds more than two results
// reset clears all framing state, empties the queue and sets rx_limit to 256
module sync_message_framer_top import smf_pkg::*; #(
  parameter int unsigned MSG_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_out_o,
  output logic        status_o,
  output logic        last_o
);

  localparam int unsigned TxCntW = $clog2(MSG_MAX + 1);

  logic      accept;
  res_pair_t pair;
  res_t      res;

  assign accept = in_valid_i && !in_stall_o;

  // framing logic
  smf_core #(
    .MsgMax (MSG_MAX),
    .TxCntW (TxCntW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .data_i     (data_i),
    .res_o      (pair)
  );

  // result queue
  smf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .pair_i  (pair),
    .full_o  (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (res)
  );

  assign kind_o     = res.kind;
  assign byte_out_o = res.data;
  assign status_o   = res.status;
  assign last_o     = res.last;

endmodule

>>> tb/framer_checker.sv
module framer_checker import smf_pkg::*; #(
  parameter int unsigned MsgMax = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  byte_out_i,
  input  logic        status_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  // framing state mirrored from the block
  logic [RxLimitW-1:0] rx_limit;
  logic                in_msg;
  logic [RxCntW-1:0]   rx_cnt;
  logic                seen_end;
  logic [6:0]          end_chr;
  logic [RxCntW-1:0]   tx_cnt;
  logic                tx_stop;

  // results still owed by the block, oldest first
  res_t due_q[$];
  res_t want;
  int   fail_cnt = 0;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, exp_val);
    fail_cnt++;
  endtask

  task automatic add_due(input kind_e k, input logic [7:0] b, input logic st,
                         input logic lst);
    res_t r;
    r.kind   = k;
    r.data   = b;
    r.status = st;
    r.last   = lst;
    due_q.push_back(r);
  endtask

  // framing step for one accepted item
  task automatic frame_item(input cmd_e cmd, input logic [7:0] data);
    logic [6:0] c;
    c = data[6:0];
    case (cmd)
      CmdRxByte: begin
        if (c == SyncChar) begin
          in_msg = 1'b1;
        end else if (in_msg) begin
          if (c == NlChar || c == NulChar) begin
            add_due(KindRxEnd, 8'h00, rx_cnt > {1'b0, rx_limit}, 1'b1);
            if (!seen_end) begin
              end_chr  = c;
              seen_end = 1'b1;
            end
            in_msg = 1'b0;
            rx_cnt = '0;
          end else begin
            if (rx_cnt != RxCntMax) rx_cnt++;
            if (rx_cnt <= {1'b0, rx_limit}) add_due(KindRxChar, {1'b0, c}, 1'b0, 1'b1);
          end
        end
      end
      CmdTxHeader: begin
        tx_cnt  = '0;
        tx_stop = 1'b0;
        add_due(KindTxByte, {1'b0, SyncChar}, 1'b0, 1'b0);
        add_due(KindTxByte, data, 1'b0, 1'b1);
      end
      CmdTxChar: begin
        if (!tx_stop) begin
          if (data == 8'h00) begin
            tx_stop = 1'b1;
          end else if (tx_cnt < MsgMax) begin
            tx_cnt++;
            add_due(KindTxByte, data, 1'b0, 1'b1);
          end
        end
      end
      default: begin
        tx_cnt  = '0;
        tx_stop = 1'b0;
        if (seen_end) begin
          add_due(KindTxByte, {1'b0, end_chr}, 1'b0, 1'b1);
        end else begin
          add_due(KindTxByte, 8'h00, 1'b0, 1'b0);
          add_due(KindTxByte, {1'b0, NlChar}, 1'b0, 1'b1);
        end
      end
    endcase
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_limit = RxLimitReset;
      in_msg   = 1'b0;
      rx_cnt   = '0;
      seen_end = 1'b0;
      end_chr  = '0;
      tx_cnt   = '0;
      tx_stop  = 1'b0;
      due_q.delete();
      pending_o    <= 0;
      fail_count_o <= fail_cnt;
    end else begin
      if (cfg_we_i) rx_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) frame_item(cmd_e'(cmd_i), data_i);
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          report_mismatch("result with nothing due, byte", byte_out_i, 0);
        end else begin
          want = due_q.pop_front();
          if (kind_i !== want.kind) report_mismatch("kind", kind_i, want.kind);
          if (byte_out_i !== want.data) report_mismatch("byte", byte_out_i, want.data);
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (last_i !== want.last) report_mismatch("last", last_i, want.last);
        end
      end
      pending_o    <= due_q.size();
      fail_count_o <= fail_cnt;
    end
  end

endmodule

>>> tb/tb.sv
module tb import smf_pkg::*;;

  localparam int unsigned MsgMax = 256;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [11:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  cmd_e        cmd;
  logic [7:0]  data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  byte_out;
  logic        status;
  logic        last;
  int          fail_count;
  int          pending;

  // stimulus controls
  logic        hold_req = 1'b0;
  logic        steady = 1'b0;
  int          sent_items = 0;
  int unsigned cur_limit = 256;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sync_message_framer_top #(.MSG_MAX(MsgMax)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd),
    .data_i      (data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .byte_out_o  (byte_out),
    .status_o    (status),
    .last_o      (last)
  );

  framer_checker #(.MsgMax(MsgMax)) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .data_i       (data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .kind_i       (kind),
    .byte_out_i   (byte_out),
    .status_i     (status),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // message character that is neither sync nor a terminator, top bit random
  function automatic logic [7:0] msg_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b[6:0] == SyncChar || b[6:0] == NlChar || b[6:0] == NulChar) b[5] = ~b[5];
    return b;
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(input cmd_e c, input logic [7:0] d);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    data     <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // wait until every owed result has come, plus settle time
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [11:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_limit = v;
  endtask

  // received message: optional junk, sync, characters, mostly a terminator
  task automatic rx_message();
    int n;
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 3)) send_item(CmdRxByte, 8'($urandom_range(0, 255)));
    end
    send_item(CmdRxByte, {1'($urandom_range(0, 1)), SyncChar});
    if (cur_limit <= 20) n = $urandom_range(0, cur_limit + 3);
    else n = $urandom_range(0, 10);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_item(CmdRxByte, {1'($urandom_range(0, 1)), SyncChar});
      send_item(CmdRxByte, msg_char());
    end
    if ($urandom_range(0, 9) != 0) begin
      send_item(CmdRxByte, {1'($urandom_range(0, 1)),
                            ($urandom_range(0, 1) ? NlChar : NulChar)});
    end
  endtask

  // outgoing message: header, characters, maybe a zero, mostly an end
  task automatic tx_message(input logic long_msg);
    int n;
    send_item(CmdTxHeader, 8'($urandom_range(0, 255)));
    n = long_msg ? MsgMax + $urandom_range(1, 6) : $urandom_range(0, 10);
    repeat (n) send_item(CmdTxChar, 8'($urandom_range(1, 255)));
    if ($urandom_range(0, 4) == 0) begin
      send_item(CmdTxChar, 8'h00);
      repeat ($urandom_range(0, 3)) send_item(CmdTxChar, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 19) != 0) send_item(CmdTxEnd, 8'($urandom_range(0, 255)));
  endtask

  // receiver: random stall stretches, plus a long hold-off on request
  initial begin
    int mode;
    int stretch;
    mode      = 0;
    stretch   = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 99);
          if (mode < 35) begin
            mode = 0;
            stretch = $urandom_range(1, 40);
          end else if (mode < 65) begin
            mode = 1;
            stretch = $urandom_range(1, 30);
          end else if (mode < 95) begin
            mode = 2;
            stretch = $urandom_range(1, 20);
          end else begin
            mode = 3;
            stretch = $urandom_range(10, 40);
          end
        end
        stretch--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [11:0] limits[6];
    int start;
    int r;
    limits   = '{12'd256, 12'd0, 12'd4095, 12'd2, 12'd17, 12'd256};
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd      = CmdRxByte;
    data     = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // end before any terminator: nul then newline
    send_item(CmdTxEnd, 8'h00);
    // terminator and junk before sync are ignored
    send_item(CmdRxByte, 8'h0a);
    send_item(CmdRxByte, 8'h41);
    // sync with top bit set, chars lose their top bit, sync skipped inside
    send_item(CmdRxByte, 8'h90);
    send_item(CmdRxByte, 8'hc1);
    send_item(CmdRxByte, 8'h10);
    send_item(CmdRxByte, 8'hff);
    send_item(CmdRxByte, 8'h01);
    // nul with top bit ends the message and is learned
    send_item(CmdRxByte, 8'h80);
    // next message waits for sync again
    send_item(CmdRxByte, 8'h42);
    send_item(CmdRxByte, 8'h10);
    send_item(CmdRxByte, 8'h8a);
    // header, full 8-bit chars, zero stops copying
    send_item(CmdTxHeader, 8'hff);
    send_item(CmdTxChar, 8'h80);
    send_item(CmdTxChar, 8'h7f);
    send_item(CmdTxChar, 8'h00);
    send_item(CmdTxChar, 8'h55);
    send_item(CmdTxEnd, 8'hff);
    // chars and end with no header
    send_item(CmdTxChar, 8'h01);
    send_item(CmdTxEnd, 8'h00);
    drain();

    // random phases, one limit setting each
    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_limit(limits[p]);
      if (p == 2 || p == 4) hold_req = 1'b1;
      if (p == 3) tx_message(1'b1);
      start = sent_items;
      while (sent_items - start < 125) begin
        steady = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 40) begin
          rx_message();
        end else if (r < 80) begin
          tx_message(1'b0);
        end else begin
          repeat ($urandom_range(1, 3)) begin
            send_item(cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          end
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/smf_pkg.sv
hw/rtl/smf_core.sv
hw/rtl/smf_outq.sv
hw/rtl/sync_message_framer_top.sv
tb/framer_checker.sv
tb/tb.sv
